### rtl/core/tbp_pkg.sv
// Shared types, constants and counter helpers for the tournament branch predictor.
// No dependencies; tbp_train, the top level and the checker use this package by scoped names.
package tbp_pkg;

    // Field widths fixed by the branch interface
    localparam int PC_W      = 10;
    localparam int LHIST_W   = 10;
    localparam int CTR_W     = 2;

    // Defaults for the top-level parameters
    localparam int DEF_TABLE_ENTRIES    = 1024;
    localparam int DEF_GLOBAL_HIST_BITS = 9;

    // Counter codes
    localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;
    localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;

    typedef logic [CTR_W-1:0] ctr_t;

    // One resolved branch
    typedef struct packed {
        logic [PC_W-1:0] pc_index;
        logic            outcome;
    } tbp_in_t;

    // One prediction result
    typedef struct packed {
        logic predicted_taken;
        logic mispredicted;
    } tbp_out_t;

    // Counter values read for one branch
    typedef struct packed {
        ctr_t local_ctr;
        ctr_t global_ctr;
        ctr_t chooser_ctr;
    } tbp_ctrs_t;

    // Saturating increment
    function automatic ctr_t sat_inc(input ctr_t c);
        ctr_t r;
        r = (c == CTR_MAX) ? CTR_MAX : ctr_t'(c + ctr_t'(1));
        return r;
    endfunction

    // Saturating decrement
    function automatic ctr_t sat_dec(input ctr_t c);
        ctr_t r;
        r = (c == CTR_MIN) ? CTR_MIN : ctr_t'(c - ctr_t'(1));
        return r;
    endfunction

endpackage

### rtl/core/tbp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/tbp_train.sv
// Prediction and training logic: picks the local or global counter through the
// chooser and forms the trained counter values. Depends on tbp_pkg.
module tbp_train (
    input  tbp_pkg::tbp_ctrs_t ctrs,
    input  logic               outcome,
    output tbp_pkg::tbp_out_t  result,
    output tbp_pkg::tbp_ctrs_t ctrs_next
);

    logic local_pred;
    logic global_pred;
    logic pred;

    // Upper half of a counter means taken; chooser below 2 trusts the local side
    assign local_pred  = ctrs.local_ctr[tbp_pkg::CTR_W-1];
    assign global_pred = ctrs.global_ctr[tbp_pkg::CTR_W-1];
    assign pred        = ctrs.chooser_ctr[tbp_pkg::CTR_W-1] ? global_pred : local_pred;

    assign result.predicted_taken = pred;
    assign result.mispredicted    = pred ^ outcome;

    // Counter training
    always_comb
    begin
        ctrs_next.chooser_ctr = ctrs.chooser_ctr;
        if ((global_pred == outcome) && (local_pred != outcome))
        begin
            ctrs_next.chooser_ctr = tbp_pkg::sat_inc(ctrs.chooser_ctr);
        end
        else if ((global_pred != outcome) && (local_pred == outcome))
        begin
            ctrs_next.chooser_ctr = tbp_pkg::sat_dec(ctrs.chooser_ctr);
        end

        if (outcome)
        begin
            ctrs_next.local_ctr  = tbp_pkg::sat_inc(ctrs.local_ctr);
            ctrs_next.global_ctr = tbp_pkg::sat_inc(ctrs.global_ctr);
        end
        else
        begin
            ctrs_next.local_ctr  = tbp_pkg::sat_dec(ctrs.local_ctr);
            ctrs_next.global_ctr = tbp_pkg::sat_dec(ctrs.global_ctr);
        end
    end

endmodule

### rtl/core/tournament_branch_predictor.sv
// Top level of the tournament branch predictor: history RAM, local counter RAM,
// shared global/chooser RAM and the sequencer. Depends on tbp_pkg, tbp_ram, tbp_train.
//
//  channel   ports                          direction  transfer at edge where
//  -------   -----------------------------  ---------  -----------------------
//  branch    start, busy, request           in         start && !busy
//  result    result_valid, result           out        result_valid
//
// Each branch passes through S_READ, which takes its local history from the history
// RAM and reads the counters (indexed by that history), then S_UPDATE, which writes
// them back. A new branch can be taken in the write-back cycle of the one before.
// After reset the block sweeps all three RAMs to zero, one entry a cycle, with busy
// high until every entry is cleared. The result shows for one cycle, in the
// write-back cycle; the receiver cannot stall it.
module tournament_branch_predictor #(
    parameter int TABLE_ENTRIES    = tbp_pkg::DEF_TABLE_ENTRIES,
    parameter int GLOBAL_HIST_BITS = tbp_pkg::DEF_GLOBAL_HIST_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tbp_pkg::tbp_in_t  request,
    output logic              result_valid,
    output tbp_pkg::tbp_out_t result
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int HYB_W = (GLOBAL_HIST_BITS + 1 > tbp_pkg::PC_W) ?
                           GLOBAL_HIST_BITS + 1 : tbp_pkg::PC_W;
    localparam int SHR_W = 2 * tbp_pkg::CTR_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_READ   = 4'b0100,
        S_UPDATE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0]            clr_reg, clr_next;
    logic [GLOBAL_HIST_BITS-1:0] ghist_reg, ghist_next;
    logic [IDX_W-1:0]            pc_slot_reg;
    logic [tbp_pkg::PC_W-1:0]    pc_reg;
    logic                        outcome_reg;
    logic [IDX_W-1:0]            lslot_reg;
    logic [IDX_W-1:0]            shared_reg;

    logic accept;
    logic clearing;

    logic [IDX_W-1:0]            req_slot;
    logic [tbp_pkg::LHIST_W-1:0] lhist;
    logic [tbp_pkg::LHIST_W-1:0] lhist_new;
    logic [HYB_W-1:0]            hybrid;
    logic [IDX_W-1:0]            lslot;
    logic [IDX_W-1:0]            shared;

    logic                        hist_we;
    logic [IDX_W-1:0]            hist_waddr;
    logic [tbp_pkg::LHIST_W-1:0] hist_wdata;
    logic                        ctr_we;
    logic [IDX_W-1:0]            lctr_waddr;
    logic [IDX_W-1:0]            shr_waddr;
    tbp_pkg::ctr_t               lctr_rdata;
    tbp_pkg::ctr_t               lctr_wdata;
    logic [SHR_W-1:0]            shr_rdata;
    logic [SHR_W-1:0]            shr_wdata;

    tbp_pkg::tbp_ctrs_t ctrs;
    tbp_pkg::tbp_ctrs_t ctrs_next;

    // Handshake
    assign clearing = (state_reg == S_CLEAR);
    assign busy     = clearing || (state_reg == S_READ);
    assign accept   = start && !busy;

    // Index formation
    assign req_slot  = IDX_W'(32'(request.pc_index) % TABLE_ENTRIES);
    assign hybrid    = HYB_W'(ghist_reg) |
                       (HYB_W'(lhist) & (HYB_W'(1) << GLOBAL_HIST_BITS));
    assign lslot     = IDX_W'(32'(lhist) % TABLE_ENTRIES);
    assign shared    = IDX_W'(32'(hybrid ^ HYB_W'(pc_reg)) % TABLE_ENTRIES);
    assign lhist_new = {lhist[tbp_pkg::LHIST_W-2:0], outcome_reg};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ghist_next = ghist_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = IDX_W'(clr_reg + IDX_W'(1));
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_UPDATE;
                ghist_next = {ghist_reg[GLOBAL_HIST_BITS-2:0], outcome_reg};
            end
            S_UPDATE:
            begin
                state_next = accept ? S_READ : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            ghist_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ghist_reg <= ghist_next;
        end
    end

    // Branch and index holding registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pc_reg      <= request.pc_index;
            pc_slot_reg <= req_slot;
            outcome_reg <= request.outcome;
        end
        if (state_reg == S_READ)
        begin
            lslot_reg  <= lslot;
            shared_reg <= shared;
        end
    end

    // Local history RAM: read on transfer, written back in the read cycle
    assign hist_we    = clearing || (state_reg == S_READ);
    assign hist_waddr = clearing ? clr_reg : pc_slot_reg;
    assign hist_wdata = clearing ? '0 : lhist_new;

    tbp_ram #(
        .WIDTH (tbp_pkg::LHIST_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (req_slot),
        .rdata (lhist)
    );

    // Counter RAMs: read in the read cycle, written back in the update cycle
    assign ctr_we     = clearing || (state_reg == S_UPDATE);
    assign lctr_waddr = clearing ? clr_reg : lslot_reg;
    assign shr_waddr  = clearing ? clr_reg : shared_reg;
    assign lctr_wdata = clearing ? tbp_pkg::CTR_MIN : ctrs_next.local_ctr;
    assign shr_wdata  = clearing ? '0 : {ctrs_next.chooser_ctr, ctrs_next.global_ctr};

    tbp_ram #(
        .WIDTH (tbp_pkg::CTR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_lctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (lctr_waddr),
        .wdata (lctr_wdata),
        .raddr (lslot),
        .rdata (lctr_rdata)
    );

    // Chooser in the upper half, global counter in the lower half
    tbp_ram #(
        .WIDTH (SHR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_shr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (shr_waddr),
        .wdata (shr_wdata),
        .raddr (shared),
        .rdata (shr_rdata)
    );

    assign ctrs.local_ctr   = lctr_rdata;
    assign ctrs.global_ctr  = shr_rdata[tbp_pkg::CTR_W-1:0];
    assign ctrs.chooser_ctr = shr_rdata[SHR_W-1:tbp_pkg::CTR_W];

    // Prediction and training
    tbp_train u_train (
        .ctrs      (ctrs),
        .outcome   (outcome_reg),
        .result    (result),
        .ctrs_next (ctrs_next)
    );

    assign result_valid = (state_reg == S_UPDATE);

endmodule

### verif/branch_prediction_checker.sv
// Checker for the tournament branch predictor: watches the branch and result channels,
// keeps its own copy of the predictor tables and compares every result it sees.
// Depends on tbp_pkg for the payload types and the default table sizes.
module branch_prediction_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  tbp_pkg::tbp_in_t  request,
    input  logic              result_valid,
    input  tbp_pkg::tbp_out_t result,
    output int                fail_count,
    output int                pending,
    output int                checked,
    output int                miss_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LHIST_W = tbp_pkg::LHIST_W;
    localparam int ENTRIES = tbp_pkg::DEF_TABLE_ENTRIES;
    localparam int GHIST_W = tbp_pkg::DEF_GLOBAL_HIST_BITS;
    localparam logic [LHIST_W-1:0] LOCAL_SEL = LHIST_W'(1) << GHIST_W;

    // Shadow copy of the predictor state
    logic [LHIST_W-1:0] hist_tab [ENTRIES];
    tbp_pkg::ctr_t      local_tab [ENTRIES];
    tbp_pkg::ctr_t      global_tab [ENTRIES];
    tbp_pkg::ctr_t      chooser_tab [ENTRIES];
    logic [GHIST_W-1:0] ghist;

    tbp_pkg::tbp_out_t expected_predictions [$];

    int fails  = 0;
    int seen   = 0;
    int misses = 0;

    assign fail_count = fails;
    assign pending    = expected_predictions.size();
    assign checked    = seen;
    assign miss_count = misses;

    // One step of a 2-bit saturating counter toward the given direction
    function automatic tbp_pkg::ctr_t nudge(input tbp_pkg::ctr_t c, input logic up);
        if (up)
            return (c == 2'd3) ? c : c + 2'd1;
        else
            return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    // Predict one branch from the current tables, then train them with its outcome
    function automatic tbp_pkg::tbp_out_t resolve_branch(input tbp_pkg::tbp_in_t br);
        logic [LHIST_W-1:0] lh;
        logic [LHIST_W-1:0] shared;
        tbp_pkg::ctr_t      lc;
        tbp_pkg::ctr_t      gc;
        tbp_pkg::ctr_t      cc;
        logic               lp;
        logic               gp;
        logic               tk;
        tbp_pkg::tbp_out_t  r;
        tk = br.outcome;
        lh = hist_tab[br.pc_index];
        // global history goes in unshifted, only OR-ed with local history bit 9
        shared = (LHIST_W'(ghist) | (lh & LOCAL_SEL)) ^ LHIST_W'(br.pc_index);
        lc = local_tab[lh];
        gc = global_tab[shared];
        cc = chooser_tab[shared];
        lp = lc[1];
        gp = gc[1];
        r.predicted_taken = (cc < 2'd2) ? lp : gp;
        r.mispredicted    = r.predicted_taken != tk;

        // chooser moves toward whichever side alone was right
        if (gp == tk && lp != tk)
            chooser_tab[shared] = nudge(cc, 1'b1);
        else if (gp != tk && lp == tk)
            chooser_tab[shared] = nudge(cc, 1'b0);
        global_tab[shared] = nudge(gc, tk);
        local_tab[lh]      = nudge(lc, tk);

        hist_tab[br.pc_index] = {lh[LHIST_W-2:0], tk};
        ghist = {ghist[GHIST_W-2:0], tk};
        return r;
    endfunction

    // Predict on each accepted branch, then compare any result of this cycle
    always @(posedge clk or negedge rst_n)
    begin
        tbp_pkg::tbp_out_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                hist_tab[i]    = '0;
                local_tab[i]   = '0;
                global_tab[i]  = '0;
                chooser_tab[i] = '0;
            end
            ghist = '0;
            expected_predictions.delete();
        end
        else
        begin
            if (start && !busy)
                expected_predictions.push_back(resolve_branch(request));
            if (result_valid)
            begin
                seen++;
                if (expected_predictions.size() == 0)
                begin
                    fails++;
                    $display("%0t: result transfer with no branch outstanding (got %b)",
                             $time, result);
                end
                else
                begin
                    want = expected_predictions.pop_front();
                    if (want.mispredicted)
                        misses++;
                    if (result.predicted_taken !== want.predicted_taken)
                    begin
                        fails++;
                        $display("%0t: predicted_taken expected %0b got %0b",
                                 $time, want.predicted_taken, result.predicted_taken);
                    end
                    if (result.mispredicted !== want.mispredicted)
                    begin
                        fails++;
                        $display("%0t: mispredicted expected %0b got %0b",
                                 $time, want.mispredicted, result.mispredicted);
                    end
                end
            end
        end
    end

endmodule

### verif/tournament_branch_predictor_test.sv
// Testbench top for the tournament branch predictor: clock, reset and branch stimulus.
// Depends on tbp_pkg, tournament_branch_predictor and branch_prediction_checker.
module tournament_branch_predictor_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PC_W            = tbp_pkg::PC_W;
    localparam int RANDOM_BRANCHES = 1800;
    localparam int IDLE_LIMIT      = 5000;
    localparam int HOT_PCS         = 8;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    tbp_pkg::tbp_in_t  request;
    logic              result_valid;
    tbp_pkg::tbp_out_t result;

    int fail_count;
    int pending;
    int checked;
    int miss_count;
    int sent = 0;
    int idle_cycles = 0;

    // Per-branch repeating outcome patterns for the well-formed traffic
    logic [PC_W-1:0] hot_pc [HOT_PCS];
    logic [9:0]      hot_pattern [HOT_PCS];
    int              hot_period [HOT_PCS];
    int              hot_phase [HOT_PCS];

    always #1 clk = ~clk;

    tournament_branch_predictor u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    branch_prediction_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .miss_count   (miss_count)
    );

    // Watchdog: too many cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("tournament_branch_predictor_test NOT OK");
            $finish;
        end
    end

    // Hold one branch on the port until it is taken; start stays high afterwards
    task automatic send_branch(input logic [PC_W-1:0] pc, input logic taken);
        start   <= 1'b1;
        request <= '{pc_index: pc, outcome: taken};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    // Pick a fresh set of hot branches with their own patterns
    task automatic shuffle_hot_set();
        for (int k = 0; k < HOT_PCS; k++)
        begin
            hot_pc[k]      = PC_W'($urandom);
            hot_pattern[k] = 10'($urandom);
            hot_period[k]  = $urandom_range(2, 10);
            hot_phase[k]   = 0;
        end
    endtask

    initial
    begin
        int              burst_left;
        int              gap;
        int              k;
        logic [PC_W-1:0] pc;
        logic            taken;

        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extreme PCs both ways, then one branch trained until its
        // local history bit 9 is set so it merges into the shared index
        send_branch('0, 1'b0);
        send_branch('0, 1'b1);
        send_branch('1, 1'b1);
        send_branch('1, 1'b0);
        repeat (11) send_branch(10'h155, 1'b1);
        repeat (4) send_branch(10'h2AA, 1'b0);
        repeat (2) send_branch(10'h155, 1'b1);

        // Random: mostly hot branches with repeating patterns, rest noise
        shuffle_hot_set();
        burst_left = 0;
        for (int n = 0; n < RANDOM_BRANCHES; n++)
        begin
            if (n % 300 == 299)
                shuffle_hot_set();
            if ($urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(0, HOT_PCS - 1);
                pc = hot_pc[k];
                taken = hot_pattern[k][hot_phase[k]];
                hot_phase[k] = (hot_phase[k] + 1) % hot_period[k];
                if ($urandom_range(0, 19) == 0)
                    taken = ~taken;
            end
            else
            begin
                pc = PC_W'($urandom);
                taken = 1'($urandom_range(0, 1));
            end
            send_branch(pc, taken);

            // Bursts with random gaps; some stretches run with no gap at all
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    start   <= 1'b0;
                    request <= tbp_pkg::tbp_in_t'($urandom);
                    repeat (gap) @(posedge clk);
                end
            end
            else
                burst_left--;
        end
        start <= 1'b0;

        // Drain outstanding results, then allow for the pipeline depth
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d branches (directed extremes, patterned and random); ", sent);
        $display("checked %0d predictions, %0d expected mispredictions", checked, miss_count);
        if (fail_count == 0)
            $display("tournament_branch_predictor_test OK");
        else
            $display("tournament_branch_predictor_test NOT OK");
        $finish;
    end

endmodule
